@@ sv/rti_pkg.sv @@
// Shared types, widths and constants for the ray/triangle intersection pipeline.
// No dependencies; every other file in this block imports this package.
package rti_pkg;

  // Number format and datapath widths.
  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 32;
  localparam int EPS_W      = 31;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CROSS_W    = PROD_W + 1;
  localparam int SPLIT_W    = 34;
  localparam int LO_W       = DIFF_W + SPLIT_W + 1;
  localparam int HI_W       = DIFF_W + CROSS_W - SPLIT_W;
  localparam int DOT_W      = 104;
  localparam int MAG_W      = DOT_W - 1;
  localparam int QUOT_W     = 33;
  localparam int NUM_W      = MAG_W + FRAC_BITS;
  localparam int NUM_LANES  = 3;
  localparam int DIV_STAGES = QUOT_W + 1;

  // Quotient lanes.
  localparam int LANE_U = 0;
  localparam int LANE_V = 1;
  localparam int LANE_T = 2;

  // Fixed-point one and the largest positive distance.
  localparam logic [QUOT_W-1:0] ONE_Q    = QUOT_W'(1) << FRAC_BITS;
  localparam logic [QUOT_W-1:0] DIST_MAX = (QUOT_W'(1) << (COORD_W - 1)) - QUOT_W'(1);

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z,
    REG_DIR_X,
    REG_DIR_Y,
    REG_DIR_Z,
    REG_DET_EPSILON,
    REG_MIN_DISTANCE
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] v0_x;
    logic signed [COORD_W-1:0] v0_y;
    logic signed [COORD_W-1:0] v0_z;
    logic signed [COORD_W-1:0] v1_x;
    logic signed [COORD_W-1:0] v1_y;
    logic signed [COORD_W-1:0] v1_z;
    logic signed [COORD_W-1:0] v2_x;
    logic signed [COORD_W-1:0] v2_y;
    logic signed [COORD_W-1:0] v2_z;
  } rti_in_t;

  typedef struct packed {
    logic                      hit;
    logic signed [COORD_W-1:0] distance;
  } rti_out_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] org;
    logic [2:0][COORD_W-1:0] dir;
  } ray_t;

  typedef struct packed {
    logic [2:0][DIFF_W-1:0]  e1;
    logic [2:0][DIFF_W-1:0]  e2;
    logic [2:0][DIFF_W-1:0]  s;
    logic [2:0][CROSS_W-1:0] h;
    logic [2:0][CROSS_W-1:0] q;
  } geom_t;

  typedef struct packed {
    logic [MAG_W-1:0]                 den;
    logic [NUM_LANES-1:0][MAG_W-1:0]  num;
    logic [NUM_LANES-1:0]             neg;
    logic                             parallel;
  } quot_in_t;

  typedef struct packed {
    logic [NUM_LANES-1:0][QUOT_W-1:0] quot;
    logic [NUM_LANES-1:0]             ovf;
    logic [NUM_LANES-1:0]             neg;
    logic                             parallel;
  } quot_out_t;

  // Magnitude of a two's complement dot product.
  function automatic logic [MAG_W-1:0] magnitude(input logic [DOT_W-1:0] x);
    logic [DOT_W-1:0] n;
    n = x[DOT_W-1] ? (~x + DOT_W'(1)) : x;
    return n[MAG_W-1:0];
  endfunction

endpackage

@@ sv/rti_front.sv @@
// Front end: edge and origin differences, then the two cross products h and q.
// Three register stages with bubble collapse; depends on rti_pkg.
module rti_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  rti_pkg::rti_in_t in_data,
  input  rti_pkg::ray_t   ray,
  output logic            out_valid,
  input  logic            out_ready,
  output rti_pkg::geom_t  out_geom
);
  import rti_pkg::*;

  localparam int STG = 3;

  logic [STG-1:0] v_r;
  logic [STG:0]   en;

  logic signed [COORD_W-1:0] p0 [3];
  logic signed [COORD_W-1:0] p1 [3];
  logic signed [COORD_W-1:0] p2 [3];
  logic signed [DIFF_W-1:0]  d [3];

  logic signed [DIFF_W-1:0] e1_1_r [3];
  logic signed [DIFF_W-1:0] e2_1_r [3];
  logic signed [DIFF_W-1:0] s_1_r [3];
  logic signed [DIFF_W-1:0] e1_2_r [3];
  logic signed [DIFF_W-1:0] e2_2_r [3];
  logic signed [DIFF_W-1:0] s_2_r [3];
  logic signed [PROD_W-1:0] hp_r [6];
  logic signed [PROD_W-1:0] qp_r [6];
  geom_t                    geom_r;

  // Stall chain: a stage loads when it is empty or its successor moves.
  assign en[STG] = out_ready;
  for (genvar k = 0; k < STG; k++) begin : g_en
    assign en[k] = !v_r[k] | en[k+1];
  end
  assign in_ready = en[0];

  // Vertex and direction operands.
  always_comb begin
    p0[0] = in_data.v0_x; p0[1] = in_data.v0_y; p0[2] = in_data.v0_z;
    p1[0] = in_data.v1_x; p1[1] = in_data.v1_y; p1[2] = in_data.v1_z;
    p2[0] = in_data.v2_x; p2[1] = in_data.v2_y; p2[2] = in_data.v2_z;
    for (int k = 0; k < 3; k++) begin
      d[k] = DIFF_W'($signed(ray.dir[k]));
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
    end
  end

  // Stage one: edges and the origin offset.
  always_ff @(posedge clk) begin
    if (en[0] && in_valid) begin
      for (int k = 0; k < 3; k++) begin
        e1_1_r[k] <= DIFF_W'(p1[k]) - DIFF_W'(p0[k]);
        e2_1_r[k] <= DIFF_W'(p2[k]) - DIFF_W'(p0[k]);
        s_1_r[k]  <= DIFF_W'($signed(ray.org[k])) - DIFF_W'(p0[k]);
      end
    end
  end

  // Stage two: the twelve cross-product terms.
  always_ff @(posedge clk) begin
    if (en[1] && v_r[0]) begin
      e1_2_r <= e1_1_r;
      e2_2_r <= e2_1_r;
      s_2_r  <= s_1_r;
      hp_r[0] <= PROD_W'(d[1]) * PROD_W'(e2_1_r[2]);
      hp_r[1] <= PROD_W'(d[2]) * PROD_W'(e2_1_r[1]);
      hp_r[2] <= PROD_W'(d[2]) * PROD_W'(e2_1_r[0]);
      hp_r[3] <= PROD_W'(d[0]) * PROD_W'(e2_1_r[2]);
      hp_r[4] <= PROD_W'(d[0]) * PROD_W'(e2_1_r[1]);
      hp_r[5] <= PROD_W'(d[1]) * PROD_W'(e2_1_r[0]);
      qp_r[0] <= PROD_W'(s_1_r[1]) * PROD_W'(e1_1_r[2]);
      qp_r[1] <= PROD_W'(s_1_r[2]) * PROD_W'(e1_1_r[1]);
      qp_r[2] <= PROD_W'(s_1_r[2]) * PROD_W'(e1_1_r[0]);
      qp_r[3] <= PROD_W'(s_1_r[0]) * PROD_W'(e1_1_r[2]);
      qp_r[4] <= PROD_W'(s_1_r[0]) * PROD_W'(e1_1_r[1]);
      qp_r[5] <= PROD_W'(s_1_r[1]) * PROD_W'(e1_1_r[0]);
    end
  end

  // Stage three: h = dir x e2 and q = s x e1.
  always_ff @(posedge clk) begin
    if (en[2] && v_r[1]) begin
      for (int k = 0; k < 3; k++) begin
        geom_r.e1[k] <= e1_2_r[k];
        geom_r.e2[k] <= e2_2_r[k];
        geom_r.s[k]  <= s_2_r[k];
        geom_r.h[k]  <= CROSS_W'(hp_r[2*k]) - CROSS_W'(hp_r[2*k+1]);
        geom_r.q[k]  <= CROSS_W'(qp_r[2*k]) - CROSS_W'(qp_r[2*k+1]);
      end
    end
  end

  assign out_valid = v_r[STG-1];
  assign out_geom  = geom_r;

endmodule

@@ sv/rti_dot.sv @@
// Dot products for the determinant and the three numerators, their magnitudes
// and the parallel test. Four register stages; depends on rti_pkg.
module rti_dot (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rti_pkg::geom_t              in_geom,
  input  rti_pkg::ray_t               ray,
  input  logic [rti_pkg::EPS_W-1:0]   det_eps,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rti_pkg::quot_in_t           out_q
);
  import rti_pkg::*;

  localparam int STG  = 4;
  localparam int NDOT = 4;

  logic [STG-1:0] v_r;
  logic [STG:0]   en;

  logic signed [DIFF_W-1:0]  xop [NDOT][3];
  logic signed [CROSS_W-1:0] yop [NDOT][3];

  logic signed [LO_W-1:0]  plo_r [NDOT][3];
  logic signed [HI_W-1:0]  phi_r [NDOT][3];
  logic signed [DOT_W-1:0] pr_r  [NDOT][3];
  logic signed [DOT_W-1:0] dot_r [NDOT];
  quot_in_t                q_r;

  logic [MAG_W-1:0] den_mag;

  assign en[STG] = out_ready;
  for (genvar k = 0; k < STG; k++) begin : g_en
    assign en[k] = !v_r[k] | en[k+1];
  end
  assign in_ready = en[0];

  // Operand pairs: a = e1.h, u = s.h, v = dir.q, t = e2.q.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      xop[0][k] = $signed(in_geom.e1[k]);
      xop[1][k] = $signed(in_geom.s[k]);
      xop[2][k] = DIFF_W'($signed(ray.dir[k]));
      xop[3][k] = $signed(in_geom.e2[k]);
      yop[0][k] = $signed(in_geom.h[k]);
      yop[1][k] = $signed(in_geom.h[k]);
      yop[2][k] = $signed(in_geom.q[k]);
      yop[3][k] = $signed(in_geom.q[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < STG; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Stage one: each wide product split into a low and a high partial product.
  always_ff @(posedge clk) begin
    if (en[0] && in_valid) begin
      for (int j = 0; j < NDOT; j++) begin
        for (int k = 0; k < 3; k++) begin
          plo_r[j][k] <= LO_W'(xop[j][k]) * $signed({1'b0, yop[j][k][SPLIT_W-1:0]});
          phi_r[j][k] <= HI_W'(xop[j][k]) * HI_W'($signed(yop[j][k][CROSS_W-1:SPLIT_W]));
        end
      end
    end
  end

  // Stage two: recombine the partial products.
  always_ff @(posedge clk) begin
    if (en[1] && v_r[0]) begin
      for (int j = 0; j < NDOT; j++) begin
        for (int k = 0; k < 3; k++) begin
          pr_r[j][k] <= (DOT_W'(phi_r[j][k]) <<< SPLIT_W) + DOT_W'(plo_r[j][k]);
        end
      end
    end
  end

  // Stage three: sum the three terms of each dot product.
  always_ff @(posedge clk) begin
    if (en[2] && v_r[1]) begin
      for (int j = 0; j < NDOT; j++) begin
        dot_r[j] <= pr_r[j][0] + pr_r[j][1] + pr_r[j][2];
      end
    end
  end

  // Stage four: magnitudes, quotient signs and the parallel test.
  assign den_mag = magnitude(dot_r[0]);

  always_ff @(posedge clk) begin
    if (en[3] && v_r[2]) begin
      q_r.den <= den_mag;
      for (int l = 0; l < NUM_LANES; l++) begin
        q_r.num[l] <= magnitude(dot_r[l+1]);
        q_r.neg[l] <= dot_r[l+1][DOT_W-1] ^ dot_r[0][DOT_W-1];
      end
      q_r.parallel <= (den_mag == '0) ||
                      (den_mag < (MAG_W'(det_eps) << (2 * FRAC_BITS)));
    end
  end

  assign out_valid = v_r[STG-1];
  assign out_q     = q_r;

endmodule

@@ sv/rti_div.sv @@
// Pipelined restoring divider for the three quotients u, v and t, one quotient bit
// per stage after the load stage, with an overflow flag for quotients past 33 bits; uses rti_pkg.
module rti_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rti_pkg::quot_in_t  in_q,
  output logic               out_valid,
  input  logic               out_ready,
  output rti_pkg::quot_out_t out_q
);
  import rti_pkg::*;

  localparam int LAST = DIV_STAGES - 1;

  logic [DIV_STAGES-1:0] v_r;
  logic [DIV_STAGES:0]   en;

  logic [MAG_W-1:0]     den_r [DIV_STAGES];
  logic [MAG_W-1:0]     rem_r [DIV_STAGES][NUM_LANES];
  logic [QUOT_W-1:0]    xq_r  [DIV_STAGES][NUM_LANES];
  logic [NUM_LANES-1:0] ovf_r [DIV_STAGES];
  logic [NUM_LANES-1:0] neg_r [DIV_STAGES];
  logic                 par_r [DIV_STAGES];

  logic [NUM_W-1:0]     x_full [NUM_LANES];
  logic [NUM_LANES-1:0] ovf_in;
  logic [MAG_W:0]       trial [DIV_STAGES][NUM_LANES];
  logic                 fits  [DIV_STAGES][NUM_LANES];

  assign en[DIV_STAGES] = out_ready;
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_en
    assign en[k] = !v_r[k] | en[k+1];
  end
  assign in_ready = en[0];

  // Scaled numerator and the test for a quotient that needs more than 33 bits.
  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      x_full[l] = {in_q.num[l], {FRAC_BITS{1'b0}}};
      ovf_in[l] = (MAG_W + QUOT_W)'(x_full[l]) >= {in_q.den, {QUOT_W{1'b0}}};
    end
  end

  // One trial subtraction per lane in each stage after stage zero.
  for (genvar k = 1; k < DIV_STAGES; k++) begin : g_step
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      assign trial[k][l] = {rem_r[k-1][l], xq_r[k-1][l][QUOT_W-1]};
      assign fits[k][l]  = trial[k][l] >= {1'b0, den_r[k-1]};
    end
  end
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane0
    assign trial[0][l] = '0;
    assign fits[0][l]  = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < DIV_STAGES; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // Stage zero loads the remainder with the top numerator bits.
  always_ff @(posedge clk) begin
    if (en[0] && in_valid) begin
      den_r[0] <= in_q.den;
      ovf_r[0] <= ovf_in;
      neg_r[0] <= in_q.neg;
      par_r[0] <= in_q.parallel;
      for (int l = 0; l < NUM_LANES; l++) begin
        rem_r[0][l] <= MAG_W'(x_full[l][NUM_W-1:QUOT_W]);
        xq_r[0][l]  <= x_full[l][QUOT_W-1:0];
      end
    end
    for (int k = 1; k < DIV_STAGES; k++) begin
      if (en[k] && v_r[k-1]) begin
        den_r[k] <= den_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
        neg_r[k] <= neg_r[k-1];
        par_r[k] <= par_r[k-1];
        for (int l = 0; l < NUM_LANES; l++) begin
          rem_r[k][l] <= fits[k][l] ? MAG_W'(trial[k][l] - {1'b0, den_r[k-1]})
                                    : trial[k][l][MAG_W-1:0];
          xq_r[k][l]  <= {xq_r[k-1][l][QUOT_W-2:0], fits[k][l]};
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      out_q.quot[l] = xq_r[LAST][l];
    end
    out_q.ovf      = ovf_r[LAST];
    out_q.neg      = neg_r[LAST];
    out_q.parallel = par_r[LAST];
  end
  assign out_valid = v_r[LAST];

endmodule

@@ sv/ray_triangle_intersect.sv @@
// Ray/triangle intersection, fixed point, one triangle per beat.
// Pipeline from input acceptance to a valid result: 3 front, 4 dot, 34 divider
// stages, 1 output register. Throughput: one beat per cycle while the output is not stalled.
// The divider's one-quotient-bit-per-stage pipeline sets the latency.
// Reset (synchronous, active low) empties the pipeline and loads the registers
// with origin 0, direction (0, 0, 1.0), epsilon 1 and minimum distance 1.
module ray_triangle_intersect (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rti_pkg::rti_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rti_pkg::rti_out_t  out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata
);
  import rti_pkg::*;

  ray_t               ray_r;
  logic [EPS_W-1:0]   eps_r;
  logic [EPS_W-1:0]   min_dist_r;

  logic      geo_valid, geo_ready;
  geom_t     geo;
  logic      qin_valid, qin_ready;
  quot_in_t  qin;
  logic      qout_valid, qout_ready;
  quot_out_t qout;

  logic                out_valid_r;
  rti_out_t            out_data_r;
  logic                en_out;
  logic [QUOT_W-1:0]   u_q, v_q, t_q;
  logic [QUOT_W:0]     u_val, v_val;
  logic                u_lt0, u_gt1, v_lt0, uv_gt1, t_low, t_sat, hit;
  rti_out_t            result;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ray_r.org    <= '0;
      ray_r.dir[0] <= '0;
      ray_r.dir[1] <= '0;
      ray_r.dir[2] <= COORD_W'(1) << FRAC_BITS;
      eps_r      <= EPS_W'(1);
      min_dist_r <= EPS_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_ORIGIN_X:     ray_r.org[0] <= cfg_wdata;
        REG_ORIGIN_Y:     ray_r.org[1] <= cfg_wdata;
        REG_ORIGIN_Z:     ray_r.org[2] <= cfg_wdata;
        REG_DIR_X:        ray_r.dir[0] <= cfg_wdata;
        REG_DIR_Y:        ray_r.dir[1] <= cfg_wdata;
        REG_DIR_Z:        ray_r.dir[2] <= cfg_wdata;
        REG_DET_EPSILON:  eps_r        <= cfg_wdata[EPS_W-1:0];
        REG_MIN_DISTANCE: min_dist_r   <= cfg_wdata[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  rti_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .ray       (ray_r),
    .out_valid (geo_valid),
    .out_ready (geo_ready),
    .out_geom  (geo)
  );

  rti_dot u_dot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (geo_valid),
    .in_ready  (geo_ready),
    .in_geom   (geo),
    .ray       (ray_r),
    .det_eps   (eps_r),
    .out_valid (qin_valid),
    .out_ready (qin_ready),
    .out_q     (qin)
  );

  rti_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (qin_valid),
    .in_ready  (qin_ready),
    .in_q      (qin),
    .out_valid (qout_valid),
    .out_ready (qout_ready),
    .out_q     (qout)
  );

  // Barycentric and distance tests on the truncated quotients.
  always_comb begin
    u_q    = qout.quot[LANE_U];
    v_q    = qout.quot[LANE_V];
    t_q    = qout.quot[LANE_T];
    u_lt0  = qout.neg[LANE_U] & (qout.ovf[LANE_U] | (u_q != '0));
    u_gt1  = !qout.neg[LANE_U] & (qout.ovf[LANE_U] | (u_q > ONE_Q));
    v_lt0  = qout.neg[LANE_V] & (qout.ovf[LANE_V] | (v_q != '0));
    u_val  = qout.neg[LANE_U] ? '0 : {1'b0, u_q};
    v_val  = qout.neg[LANE_V] ? '0 : {1'b0, v_q};
    uv_gt1 = !qout.neg[LANE_V] & (qout.ovf[LANE_V] | ((u_val + v_val) > {1'b0, ONE_Q}));
    t_low  = qout.neg[LANE_T] |
             (!qout.ovf[LANE_T] & (t_q <= QUOT_W'(min_dist_r)));
    t_sat  = qout.ovf[LANE_T] | (t_q > DIST_MAX);
    hit    = !qout.parallel & !u_lt0 & !u_gt1 & !v_lt0 & !uv_gt1 & !t_low;
    result.hit      = hit;
    result.distance = !hit ? '0 : (t_sat ? $signed(DIST_MAX[COORD_W-1:0])
                                         : $signed(t_q[COORD_W-1:0]));
  end

  // Output register: the last pipeline stage.
  assign en_out     = !out_valid_r | out_ready;
  assign qout_ready = en_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= qout_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && qout_valid) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // A reported hit never lies before the minimum distance; saturation may meet it.
  a_hit_beyond_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> out_data.distance >= $signed({1'b0, min_dist_r}))
    else $error("hit reported before the minimum distance");

  // A miss carries a zero distance.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.distance == '0)
    else $error("miss with a nonzero distance");

  // The input side only stalls while a result waits at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a blocked output");
`endif

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the fixed-point ray/triangle intersection pipeline.
// It depends on rti_pkg and ray_triangle_intersect, and predicts every result internally.
module testbench;
  import rti_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef wide_t vec3_t [3];

  // Hit-test predictor with a queue of expected hit/distance beats.
  class hit_scoreboard;
    logic [31:0] ray_reg [8];
    rti_out_t    hit_queue [$];
    int          errors;

    function new();
      reset_regs();
      errors = 0;
    endfunction

    function void reset_regs();
      foreach (ray_reg[i]) ray_reg[i] = '0;
      ray_reg[REG_DIR_Z]        = 32'h0001_0000;
      ray_reg[REG_DET_EPSILON]  = 32'd1;
      ray_reg[REG_MIN_DISTANCE] = 32'd1;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [31:0] val);
      ray_reg[idx] = val;
    endfunction

    function automatic wide_t sx(logic [31:0] x);
      return wide_t'({{96{x[31]}}, x});
    endfunction

    function automatic void cross3(input vec3_t a, input vec3_t b, output vec3_t r);
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic wide_t dot(input vec3_t a, input vec3_t b);
      return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    // Truncated Q16.16 ratio, clamped to a magnitude of 2^62.
    function automatic logic signed [63:0] ratio(wide_t num, wide_t den);
      logic [127:0] n;
      logic [127:0] d;
      logic [127:0] m;
      logic         neg;
      neg = num[127] ^ den[127];
      n = num[127] ? -num : num;
      d = den[127] ? -den : den;
      m = (n << FRAC_BITS) / d;
      if (m > (128'd1 << 62)) m = 128'd1 << 62;
      return neg ? -$signed(m[63:0]) : $signed(m[63:0]);
    endfunction

    function automatic rti_out_t predict(rti_in_t tgl);
      vec3_t p0, p1, p2, org, dir, e1, e2, s, h, q;
      wide_t a, eps, mag;
      logic signed [63:0] u, v, t, one, min_d;
      rti_out_t r;
      r = '0;
      one = 64'sd1 <<< FRAC_BITS;
      p0[0] = sx(tgl.v0_x); p0[1] = sx(tgl.v0_y); p0[2] = sx(tgl.v0_z);
      p1[0] = sx(tgl.v1_x); p1[1] = sx(tgl.v1_y); p1[2] = sx(tgl.v1_z);
      p2[0] = sx(tgl.v2_x); p2[1] = sx(tgl.v2_y); p2[2] = sx(tgl.v2_z);
      org[0] = sx(ray_reg[REG_ORIGIN_X]); org[1] = sx(ray_reg[REG_ORIGIN_Y]);
      org[2] = sx(ray_reg[REG_ORIGIN_Z]);
      dir[0] = sx(ray_reg[REG_DIR_X]); dir[1] = sx(ray_reg[REG_DIR_Y]);
      dir[2] = sx(ray_reg[REG_DIR_Z]);
      for (int k = 0; k < 3; k++) begin
        e1[k] = p1[k] - p0[k];
        e2[k] = p2[k] - p0[k];
        s[k]  = org[k] - p0[k];
      end
      cross3(dir, e2, h);
      a = dot(e1, h);
      // The epsilon register is 31 bits wide; its top write bit is dropped.
      eps = wide_t'({97'd0, ray_reg[REG_DET_EPSILON][30:0]}) <<< (2 * FRAC_BITS);
      mag = a[127] ? -a : a;
      if (a == 0 || mag < eps) return r;
      u = ratio(dot(s, h), a);
      if (u < 0 || u > one) return r;
      cross3(s, e1, q);
      v = ratio(dot(dir, q), a);
      if (v < 0 || u + v > one) return r;
      t = ratio(dot(e2, q), a);
      min_d = {33'd0, ray_reg[REG_MIN_DISTANCE][30:0]};
      if (t <= min_d) return r;
      r.hit = 1'b1;
      r.distance = (t > 64'sh7FFF_FFFF) ? 32'sh7FFF_FFFF : t[31:0];
      return r;
    endfunction

    function void note_input(rti_in_t tgl);
      hit_queue.push_back(predict(tgl));
    endfunction

    function void check_result(rti_out_t got);
      rti_out_t exp_r;
      if (hit_queue.size() == 0) begin
        $error("result beat with no expected result waiting");
        errors++;
        return;
      end
      exp_r = hit_queue.pop_front();
      if (got.hit !== exp_r.hit) begin
        $error("hit: expected %0b, actual %0b", exp_r.hit, got.hit);
        errors++;
      end
      if (got.distance !== exp_r.distance) begin
        $error("distance: expected %0d, actual %0d", exp_r.distance, got.distance);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  rti_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  rti_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  hit_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int cycles = 0;

  always #5 clk = ~clk;

  ray_triangle_intersect i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_addr, .cfg_wdata
  );

  // Receiver back-pressure, changed on the falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Check every accepted result beat.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic cfg_write(cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_ray(logic [31:0] ox, oy, oz, dx, dy, dz, eps, mind);
    cfg_write(REG_ORIGIN_X, ox);
    cfg_write(REG_ORIGIN_Y, oy);
    cfg_write(REG_ORIGIN_Z, oz);
    cfg_write(REG_DIR_X, dx);
    cfg_write(REG_DIR_Y, dy);
    cfg_write(REG_DIR_Z, dz);
    cfg_write(REG_DET_EPSILON, eps);
    cfg_write(REG_MIN_DISTANCE, mind);
  endtask

  // Present one triangle beat; called at a falling edge, returns at one.
  task automatic send_triangle(rti_in_t tgl);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = tgl;
    do @(posedge clk); while (!in_ready);
    sb.note_input(tgl);
    @(negedge clk);
  endtask

  // Hold off the sender until every expected result has arrived.
  task automatic drain();
    in_valid = 1'b0;
    while (sb.hit_queue.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic rti_in_t make_tri(logic signed [31:0] x0, y0, z0, x1, y1, z1,
                                       x2, y2, z2);
    rti_in_t t;
    t.v0_x = x0; t.v0_y = y0; t.v0_z = z0;
    t.v1_x = x1; t.v1_y = y1; t.v1_z = z1;
    t.v2_x = x2; t.v2_y = y2; t.v2_z = z2;
    return t;
  endfunction

  function automatic logic [31:0] corner_val();
    case ($urandom_range(4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'(signed'($urandom_range(131072)) - 65536);
      default: return $urandom;
    endcase
  endfunction

  // Mostly triangles placed around a point on the ray, the rest noise.
  function automatic rti_in_t random_triangle();
    logic [31:0] w [9];
    logic [31:0] centre [3];
    int sel, m, spread;
    sel = $urandom_range(99);
    m = $urandom_range(1, 8);
    spread = $urandom_range(6, 20);
    for (int k = 0; k < 3; k++)
      centre[k] = sb.ray_reg[k] + sb.ray_reg[3 + k] * m;
    for (int i = 0; i < 9; i++) begin
      if (sel < 70)
        w[i] = centre[i % 3] + 32'(signed'($urandom_range((1 << spread) * 2))
                                  - (1 << spread));
      else if (sel < 85)
        w[i] = $urandom;
      else
        w[i] = corner_val();
    end
    return make_tri(w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8]);
  endfunction

  task automatic random_phase(int n);
    repeat (n) send_triangle(random_triangle());
  endtask

  function automatic logic [31:0] rnd_small(int bits);
    return 32'(signed'($urandom_range((1 << bits) * 2)) - (1 << bits));
  endfunction

  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset ray: origin zero, looking along +z, sender 38 % and receiver 76 % idle.
    tx_idle_pct = 38;
    rx_idle_pct = 76;
    // Plain hit at distance five.
    send_triangle(make_tri(-ONE, -ONE, 5 * ONE, ONE, -ONE, 5 * ONE, 0, ONE, 5 * ONE));
    // Triangle behind the origin.
    send_triangle(make_tri(-ONE, -ONE, -5 * ONE, ONE, -ONE, -5 * ONE, 0, ONE, -5 * ONE));
    // Triangle in a plane containing the ray: zero determinant.
    send_triangle(make_tri(0, -ONE, ONE, 0, ONE, 2 * ONE, 0, 0, 3 * ONE));
    // Degenerate triangle with all vertices equal.
    send_triangle(make_tri(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE));
    // Determinant under the threshold: tiny edges.
    send_triangle(make_tri(0, 0, ONE, 1, 0, ONE, 0, 1, ONE));
    // u below zero, u above one, v below zero, u + v above one.
    send_triangle(make_tri(ONE, 0, ONE, 2 * ONE, 0, ONE, ONE, ONE, ONE));
    send_triangle(make_tri(-2 * ONE, 0, ONE, -ONE, 0, ONE, -2 * ONE, ONE, ONE));
    send_triangle(make_tri(0, ONE, ONE, ONE, ONE, ONE, 0, 2 * ONE, ONE));
    send_triangle(make_tri(-ONE, -ONE, ONE, -ONE, -ONE / 2, ONE, -ONE / 2, -ONE, ONE));
    // Vertex and edge hits: u exactly one, v exactly zero.
    send_triangle(make_tri(-ONE, 0, ONE, 0, 0, ONE, -ONE, ONE, ONE));
    send_triangle(make_tri(0, 0, ONE, ONE, 0, ONE, 0, ONE, ONE));
    // Distance equal to and just above the minimum distance.
    send_triangle(make_tri(-ONE, -ONE, 1, ONE, -ONE, 1, 0, ONE, 1));
    send_triangle(make_tri(-ONE, -ONE, 2, ONE, -ONE, 2, 0, ONE, 2));
    // Far triangle and field extremes.
    send_triangle(make_tri(-ONE, -ONE, 32'sh7FFF_FFFF, ONE, -ONE, 32'sh7FFF_FFFF,
                           0, ONE, 32'sh7FFF_FFFF));
    send_triangle(make_tri('1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1,
                           '1 >> 1, '1 >> 1, '1 >> 1));
    send_triangle('1);
    send_triangle('0);
    send_triangle(make_tri(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                           32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                           32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    random_phase(130);
    drain();

    // A general ray with small thresholds.
    set_ray(rnd_small(20), rnd_small(20), rnd_small(20), rnd_small(17), rnd_small(17),
            rnd_small(17), $urandom_range(255), $urandom_range(255));
    random_phase(150);
    drain();

    // Register extremes, with the unused top bit of the thresholds set.
    tx_idle_pct = 76;
    rx_idle_pct = 38;
    set_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_phase(150);
    drain();

    // Tiny direction, zero thresholds: huge quotients and saturated distances.
    set_ray(0, 0, 0, 0, 0, 1, 0, 0);
    send_triangle(make_tri(-ONE, -ONE, 5 * ONE, ONE, -ONE, 5 * ONE, 0, ONE, 5 * ONE));
    send_triangle(make_tri(0, 0, 3, 1, 0, 3, 0, 1, 3));
    send_triangle(make_tri(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0));
    send_triangle(make_tri(0, -ONE, ONE, 0, ONE, 2 * ONE, 0, 0, 3 * ONE));
    random_phase(150);
    drain();

    // Further random rays with no idling on either side.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (3) begin
      set_ray(rnd_small(24), rnd_small(24), rnd_small(24), rnd_small(18), rnd_small(18),
              rnd_small(18), $urandom_range(4095), $urandom_range(1 << 18));
      random_phase(150);
      drain();
    end

    if (sb.hit_queue.size() == 0 && sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/rti_pkg.sv
sv/rti_front.sv
sv/rti_dot.sv
sv/rti_div.sv
sv/ray_triangle_intersect.sv
tb/sv/testbench.sv
